### rtl/core/assert_macros.svh
// Assertion macros shared by the rule lookup core.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the user scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define NWRL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nwrl assertion failed");

// Next-cycle implication, checked only outside reset.
`define NWRL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nwrl assertion failed");

`endif

### rtl/core/nwrl_pkg.sv
// Package of the NAT wildcard rule lookup core: sizes, codes and payload types.
// Used by every module of the core; depends on nothing.
package nwrl_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int ADDR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int RULE_INDEX_W = 4;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_XLAT    = 3'd0,
        ST_NOMATCH = 3'd1,
        ST_STORED  = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [15:0] port;
        logic        addr_any;
        logic        port_any;
        logic [31:0] xlat_addr;
        logic [15:0] xlat_port;
    } t_req;

    typedef struct packed {
        t_status                   status;
        logic [31:0]               out_addr;
        logic [15:0]               out_port;
        logic [RULE_INDEX_W-1:0]   rule_index;
    } t_rsp;

    typedef struct packed {
        logic        port_any;
        logic        addr_any;
        logic [15:0] port;
        logic [31:0] addr;
    } t_match_entry;

    typedef struct packed {
        logic [15:0] port;
        logic [31:0] addr;
    } t_xlat_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_match_entry      match;
        t_xlat_entry       xlat;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

endpackage

### rtl/core/nwrl_rule_mem.sv
// Rule memory of the lookup core: match and translation stores, one write and one read port.
// Depends on nwrl_pkg; the read data is registered.
module nwrl_rule_mem (
    input  logic                  i_clk,
    input  nwrl_pkg::t_mem_wr     i_wr,
    input  nwrl_pkg::t_mem_rd     i_rd,
    output nwrl_pkg::t_match_entry o_rd_match,
    output nwrl_pkg::t_xlat_entry  o_rd_xlat
);

    nwrl_pkg::t_match_entry match_mem [nwrl_pkg::TABLE_DEPTH];
    nwrl_pkg::t_xlat_entry  xlat_mem  [nwrl_pkg::TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            match_mem[i_wr.addr] <= i_wr.match;
            xlat_mem[i_wr.addr]  <= i_wr.xlat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            o_rd_match <= match_mem[i_rd.addr];
            o_rd_xlat  <= xlat_mem[i_rd.addr];
        end
    end

endmodule

### rtl/core/nwrl_match_cmp.sv
// Rule comparator of the lookup core: tests one stored rule against a flow key.
// Depends on nwrl_pkg; purely combinational.
module nwrl_match_cmp (
    input  nwrl_pkg::t_match_entry i_rule,
    input  logic [31:0]            i_key_addr,
    input  logic [15:0]            i_key_port,
    output logic                   o_hit
);

    logic addr_ok;
    logic port_ok;

    // A wildcard bit makes its half of the rule match any value.
    assign addr_ok = i_rule.addr_any || (i_rule.addr == i_key_addr);
    assign port_ok = i_rule.port_any || (i_rule.port == i_key_port);
    assign o_hit   = addr_ok && port_ok;

endmodule

### rtl/core/nat_wildcard_rule_lookup_core.sv
// Top level of the NAT wildcard rule lookup core: command decode, scan sequencer, result register.
// Depends on nwrl_pkg, nwrl_rule_mem, nwrl_match_cmp and assert_macros.svh.

// A transaction is accepted when start is high while busy is low, and every transaction
// yields exactly one result, shown on o_rsp for a single cycle with o_valid high; the
// receiver cannot stall, so it must take each result in the cycle in which it appears.
// Clear, load and any lookup on an empty table answer in the cycle after acceptance and
// leave busy low, so such transactions may follow one another in every cycle. A lookup on
// a non-empty table walks the rules from the oldest to the newest through the single read
// port of the rule memory, one rule per cycle, and stops at the first matching rule, or
// after the newest stored rule when none matches. Busy is high while the walk lasts and
// drops in the cycle in which the result appears. The stores need no clearing pass after
// reset: only the rule count is reset, and entries at or beyond it are never read.

`include "assert_macros.svh"

module nat_wildcard_rule_lookup_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  nwrl_pkg::t_req i_req,
    output logic           busy,
    output logic           o_valid,
    output nwrl_pkg::t_rsp o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    // Sequencer state and scan bookkeeping.
    t_state                         r_state, n_state;
    logic [nwrl_pkg::CNT_W-1:0]     r_count, n_count;
    logic [nwrl_pkg::CNT_W-1:0]     r_issue, n_issue;
    logic                           r_chk_vld;
    logic [nwrl_pkg::ADDR_W-1:0]    r_chk_idx;
    logic [31:0]                    r_key_addr, n_key_addr;
    logic [15:0]                    r_key_port, n_key_port;

    // Result register.
    logic                           r_valid, n_valid;
    nwrl_pkg::t_rsp                 r_rsp, n_rsp;

    nwrl_pkg::t_mem_wr              mem_wr;
    nwrl_pkg::t_mem_rd              mem_rd;
    nwrl_pkg::t_match_entry         rd_match;
    nwrl_pkg::t_xlat_entry          rd_xlat;
    logic                           hit;
    logic                           accept;
    logic                           last_rule;

    assign accept = start && !busy;
    assign busy   = (r_state == S_SCAN);

    nwrl_rule_mem u_mem (
        .i_clk      (i_clk),
        .i_wr       (mem_wr),
        .i_rd       (mem_rd),
        .o_rd_match (rd_match),
        .o_rd_xlat  (rd_xlat)
    );

    // The comparator sees the rule read in the previous cycle against the stored key.
    nwrl_match_cmp u_cmp (
        .i_rule     (rd_match),
        .i_key_addr (r_key_addr),
        .i_key_port (r_key_port),
        .o_hit      (hit)
    );

    // The rule under test is the newest one stored when its index is one below the count.
    assign last_rule = (nwrl_pkg::CNT_W'(r_chk_idx) == (r_count - nwrl_pkg::CNT_W'(1)));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_issue    = r_issue;
        n_key_addr = r_key_addr;
        n_key_port = r_key_port;
        n_valid    = 1'b0;
        n_rsp      = r_rsp;

        mem_wr.en    = 1'b0;
        mem_wr.addr  = r_count[nwrl_pkg::ADDR_W-1:0];
        mem_wr.match = '{port_any: i_req.port_any, addr_any: i_req.addr_any,
                         port: i_req.port, addr: i_req.addr};
        mem_wr.xlat  = '{port: i_req.xlat_port, addr: i_req.xlat_addr};
        mem_rd.en    = 1'b0;
        mem_rd.addr  = r_issue[nwrl_pkg::ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    n_rsp   = '{status: nwrl_pkg::ST_NOMATCH, out_addr: '0, out_port: '0,
                                rule_index: '0};
                    case (i_req.op)
                        nwrl_pkg::OP_CLEAR: begin
                            n_count      = '0;
                            n_rsp.status = nwrl_pkg::ST_CLEARED;
                        end
                        nwrl_pkg::OP_LOAD: begin
                            if (r_count >= nwrl_pkg::CNT_W'(nwrl_pkg::TABLE_DEPTH)) begin
                                n_rsp.status = nwrl_pkg::ST_FULL;
                            end else begin
                                mem_wr.en        = 1'b1;
                                n_count          = r_count + nwrl_pkg::CNT_W'(1);
                                n_rsp.status     = nwrl_pkg::ST_STORED;
                                n_rsp.rule_index = nwrl_pkg::RULE_INDEX_W'(
                                    r_count[nwrl_pkg::ADDR_W-1:0]);
                            end
                        end
                        nwrl_pkg::OP_LOOKUP: begin
                            // An empty table misses at once; otherwise start the walk at
                            // the oldest rule.
                            if (r_count != '0) begin
                                n_valid     = 1'b0;
                                n_state     = S_SCAN;
                                n_key_addr  = i_req.addr;
                                n_key_port  = i_req.port;
                                mem_rd.en   = 1'b1;
                                mem_rd.addr = '0;
                                n_issue     = nwrl_pkg::CNT_W'(1);
                            end
                        end
                        default: begin
                            // The unused code changes nothing and reports no match.
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_chk_vld && hit) begin
                    n_valid = 1'b1;
                    n_rsp   = '{status: nwrl_pkg::ST_XLAT, out_addr: rd_xlat.addr,
                                out_port: rd_xlat.port,
                                rule_index: nwrl_pkg::RULE_INDEX_W'(r_chk_idx)};
                    n_state = S_IDLE;
                end else if (r_chk_vld && last_rule) begin
                    n_valid = 1'b1;
                    n_rsp   = '{status: nwrl_pkg::ST_NOMATCH, out_addr: '0, out_port: '0,
                                rule_index: '0};
                    n_state = S_IDLE;
                end else if (r_issue < r_count) begin
                    // Keep one read in flight so that a rule is tested in every cycle.
                    mem_rd.en = 1'b1;
                    n_issue   = r_issue + nwrl_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_issue   <= '0;
            r_chk_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_issue   <= n_issue;
            r_chk_vld <= mem_rd.en;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd.en) begin
            r_chk_idx <= mem_rd.addr;
        end
        r_key_addr <= n_key_addr;
        r_key_port <= n_key_port;
        r_rsp      <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Every accepted transaction either answers in the next cycle or holds the block busy.
    `NWRL_ASSERT_NXT(a_accept_progress, accept, (o_valid || busy))
    // A result never appears while a walk is still in progress.
    `NWRL_ASSERT_IMP(a_no_result_while_busy, busy, !o_valid)
    // The rule count never exceeds the table depth.
    `NWRL_ASSERT_IMP(a_count_bound, 1'b1, (r_count <= nwrl_pkg::CNT_W'(nwrl_pkg::TABLE_DEPTH)))
    // Only a translation carries a non-zero address or port.
    `NWRL_ASSERT_IMP(a_zero_unless_xlat, (o_valid && (o_rsp.status != nwrl_pkg::ST_XLAT)),
        ((o_rsp.out_addr == '0) && (o_rsp.out_port == '0)))

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the NAT wildcard rule lookup core: clear, load and lookup
// transactions, directed then random, checked against a first-match rule table kept here.
// Depends on nwrl_pkg and nat_wildcard_rule_lookup_core.

module testbench;

    // The two-bit op field has one code that the block does not use.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Cycles without any accepted transaction or result before the run is abandoned.
    // The slowest transaction walks the whole table, and the sender's gaps come at
    // 72 idles in a hundred at most, so this is ample.
    localparam int STALL_LIMIT   = 4000;
    // Cycles allowed after the last expected result, in case the block emits a stray one.
    localparam int DRAIN_CYCLES  = nwrl_pkg::TABLE_DEPTH + 8;
    localparam int RANDOM_ITEMS  = 400;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    nwrl_pkg::t_req i_req   = '0;
    logic           busy;
    logic           o_valid;
    nwrl_pkg::t_rsp o_rsp;

    nat_wildcard_rule_lookup_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // Transactions waiting to be presented, and results waiting to be seen.
    nwrl_pkg::t_req pending_req[$];
    nwrl_pkg::t_rsp expected_rsp[$];

    int unsigned n_items;
    int unsigned n_sent;
    int unsigned n_accepted;
    int unsigned n_errors;
    int unsigned stall_cycles;
    // Raised at the rising edge that accepts a transaction, consumed by the driver at
    // the following falling edge.
    bit          accept_seen;

    // Rule table of the predictor: entries beyond rule_total are never consulted.
    nwrl_pkg::t_match_entry rule_match [nwrl_pkg::TABLE_DEPTH];
    nwrl_pkg::t_xlat_entry  rule_xlat  [nwrl_pkg::TABLE_DEPTH];
    int unsigned            rule_total;

    // Rules that the stimulus has loaded since the last clear, so that lookups can be
    // aimed at them. Loads into a full table are left out, as the block drops them.
    nwrl_pkg::t_match_entry loaded_rules[$];
    logic [31:0]            addr_pool [4];
    logic [15:0]            port_pool [4];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Works out the result of one transaction and updates the rule table to match.
    function automatic nwrl_pkg::t_rsp predict_translation(input nwrl_pkg::t_req req);
        nwrl_pkg::t_rsp rsp;
        bit             hit;
        rsp        = '0;
        rsp.status = nwrl_pkg::ST_NOMATCH;
        hit        = 1'b0;
        case (req.op)
            nwrl_pkg::OP_CLEAR: begin
                rule_total = 0;
                rsp.status = nwrl_pkg::ST_CLEARED;
            end
            nwrl_pkg::OP_LOAD: begin
                if (rule_total >= nwrl_pkg::TABLE_DEPTH) begin
                    rsp.status = nwrl_pkg::ST_FULL;
                end else begin
                    rule_match[rule_total] = '{port_any: req.port_any, addr_any: req.addr_any,
                                               port: req.port, addr: req.addr};
                    rule_xlat[rule_total]  = '{port: req.xlat_port, addr: req.xlat_addr};
                    rsp.status             = nwrl_pkg::ST_STORED;
                    rsp.rule_index         = nwrl_pkg::RULE_INDEX_W'(rule_total);
                    rule_total++;
                end
            end
            nwrl_pkg::OP_LOOKUP: begin
                // Oldest rule first; the first hit wins.
                for (int i = 0; i < rule_total && !hit; i++) begin
                    if ((rule_match[i].addr_any || rule_match[i].addr == req.addr) &&
                        (rule_match[i].port_any || rule_match[i].port == req.port)) begin
                        hit            = 1'b1;
                        rsp.status     = nwrl_pkg::ST_XLAT;
                        rsp.out_addr   = rule_xlat[i].addr;
                        rsp.out_port   = rule_xlat[i].port;
                        rsp.rule_index = nwrl_pkg::RULE_INDEX_W'(i);
                    end
                end
            end
            default: begin
                // The spare op changes nothing and reports no match.
            end
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // A transaction with every field random, the spare op included.
    function automatic nwrl_pkg::t_req random_req();
        nwrl_pkg::t_req req;
        req.op        = 2'($urandom_range(0, 3));
        req.addr      = $urandom;
        req.port      = 16'($urandom);
        req.addr_any  = 1'($urandom);
        req.port_any  = 1'($urandom);
        req.xlat_addr = $urandom;
        req.xlat_port = 16'($urandom);
        return req;
    endfunction

    // Fields that the op ignores, and the translation of a load, stay random.
    function automatic nwrl_pkg::t_req make_req(input logic [1:0] op, input logic [31:0] addr,
                                                input logic [15:0] port, input logic aany,
                                                input logic pany);
        nwrl_pkg::t_req req;
        req          = random_req();
        req.op       = op;
        req.addr     = addr;
        req.port     = port;
        req.addr_any = aany;
        req.port_any = pany;
        return req;
    endfunction

    function automatic logic [31:0] pick_addr();
        return ($urandom_range(0, 3) == 0) ? $urandom : addr_pool[$urandom_range(0, 3)];
    endfunction

    function automatic logic [15:0] pick_port();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 3)];
    endfunction

    task automatic queue_item(input nwrl_pkg::t_req req);
        pending_req.insert(pending_req.size(), req);
        if (req.op == nwrl_pkg::OP_CLEAR) begin
            loaded_rules.delete();
        end else if (req.op == nwrl_pkg::OP_LOAD &&
                     loaded_rules.size() < nwrl_pkg::TABLE_DEPTH) begin
            loaded_rules.insert(loaded_rules.size(),
                                '{port_any: req.port_any, addr_any: req.addr_any,
                                  port: req.port, addr: req.addr});
        end
    endtask

    // A lookup aimed at a loaded rule most of the time, so that hits are common and
    // rules sharing an address or a port compete for the first match.
    task automatic queue_lookup();
        nwrl_pkg::t_match_entry rule;
        logic [31:0]            addr;
        logic [15:0]            port;
        if (loaded_rules.size() != 0 && $urandom_range(0, 9) < 7) begin
            rule = loaded_rules[$urandom_range(0, loaded_rules.size() - 1)];
            addr = rule.addr_any ? pick_addr() : rule.addr;
            port = rule.port_any ? pick_port() : rule.port;
        end else begin
            addr = pick_addr();
            port = pick_port();
        end
        queue_item(make_req(nwrl_pkg::OP_LOOKUP, addr, port, 1'($urandom), 1'($urandom)));
    endtask

    // Driver: inputs change only at the falling edge. A presented transaction is held
    // until the rising edge that accepts it; the sender's idling is decided only when
    // a new transaction could be presented.
    always @(negedge i_clk) begin : driver_proc
        nwrl_pkg::t_req next_req;
        logic           next_start;
        int unsigned    idle_pct;
        next_req   = i_req;
        next_start = start;
        if (accept_seen) begin
            accept_seen = 1'b0;
            next_start  = 1'b0;
        end
        if (i_rst_n && !next_start && pending_req.size() != 0) begin
            // First third sparse gaps, second third frequent gaps, last third none.
            if (n_sent < n_items / 3) begin
                idle_pct = 6;
            end else if (n_sent < (2 * n_items) / 3) begin
                idle_pct = 72;
            end else begin
                idle_pct = 0;
            end
            if ($urandom_range(0, 99) >= idle_pct) begin
                next_req   = pending_req.pop_front();
                next_start = 1'b1;
                n_sent++;
            end
        end
        start <= next_start;
        i_req <= next_req;
    end

    // Monitor: the result of this edge is checked before any transaction accepted at
    // the same edge is predicted, so the queue order never depends on process order.
    always @(posedge i_clk) begin : monitor_proc
        nwrl_pkg::t_rsp want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, status %0d",
                                          o_rsp.status));
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_rsp.status, want.status));
                if (o_rsp.out_addr !== want.out_addr)
                    report_mismatch($sformatf("out_addr %h, expected %h",
                                              o_rsp.out_addr, want.out_addr));
                if (o_rsp.out_port !== want.out_port)
                    report_mismatch($sformatf("out_port %h, expected %h",
                                              o_rsp.out_port, want.out_port));
                if (o_rsp.rule_index !== want.rule_index)
                    report_mismatch($sformatf("rule_index %0d, expected %0d",
                                              o_rsp.rule_index, want.rule_index));
            end
        end
        if (i_rst_n && start && busy === 1'b0) begin
            expected_rsp.insert(expected_rsp.size(), predict_translation(i_req));
            n_accepted++;
            accept_seen = 1'b1;
        end
    end

    // Watchdog: any accepted transaction or result restarts the count.
    always @(posedge i_clk) begin : watchdog_proc
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus_proc
        nwrl_pkg::t_req req;
        int unsigned    n_random;
        int unsigned    n_rules;
        int unsigned    n_lookups;

        // Small pools of addresses and ports make overlapping rules likely; the
        // extremes of both fields are always among them.
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        addr_pool[2] = $urandom;
        addr_pool[3] = $urandom;
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        port_pool[2] = 16'($urandom);
        port_pool[3] = 16'($urandom);

        // Directed part. A lookup on the empty table, with the wildcard bits set to
        // show that they are ignored on a lookup.
        queue_item(make_req(nwrl_pkg::OP_LOOKUP, 32'h0, 16'h0, 1'b1, 1'b1));
        queue_item(make_req(OP_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1));
        queue_item(make_req(nwrl_pkg::OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1));
        // Exact rules at both extremes, with extreme translations.
        req           = make_req(nwrl_pkg::OP_LOAD, 32'h0, 16'h0, 1'b0, 1'b0);
        req.xlat_addr = 32'hFFFF_FFFF;
        req.xlat_port = 16'hFFFF;
        queue_item(req);
        req           = make_req(nwrl_pkg::OP_LOAD, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0);
        req.xlat_addr = 32'h0;
        req.xlat_port = 16'h0;
        queue_item(req);
        // One wildcard each.
        queue_item(make_req(nwrl_pkg::OP_LOAD, $urandom, port_pool[2], 1'b1, 1'b0));
        queue_item(make_req(nwrl_pkg::OP_LOAD, addr_pool[2], 16'($urandom), 1'b0, 1'b1));
        // Fill up to one short of full with exact rules.
        for (int i = 4; i < nwrl_pkg::TABLE_DEPTH - 1; i++) begin
            queue_item(make_req(nwrl_pkg::OP_LOAD, pick_addr(), pick_port(), 1'b0, 1'b0));
        end
        // A flow that no rule matches while no rule matches everything.
        queue_item(make_req(nwrl_pkg::OP_LOOKUP, 32'h1234_5678, 16'h4321, 1'b0, 1'b0));
        // The rule with both wildcards takes the last slot, then the table is full.
        queue_item(make_req(nwrl_pkg::OP_LOAD, $urandom, 16'($urandom), 1'b1, 1'b1));
        queue_item(make_req(nwrl_pkg::OP_LOAD, $urandom, 16'($urandom), 1'b0, 1'b0));
        queue_item(make_req(nwrl_pkg::OP_LOOKUP, 32'h0, 16'h0, 1'b0, 1'b0));
        queue_item(make_req(nwrl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0));
        queue_item(make_req(nwrl_pkg::OP_LOOKUP, $urandom, port_pool[2], 1'b0, 1'b0));
        queue_item(make_req(nwrl_pkg::OP_LOOKUP, addr_pool[2], 16'($urandom), 1'b1, 1'b1));
        queue_item(make_req(nwrl_pkg::OP_LOOKUP, $urandom, 16'($urandom), 1'b0, 1'b0));

        // Random part: mostly a clear, a run of loads and a run of lookups, now and
        // then a fully random transaction as noise.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_item(random_req());
                n_random++;
            end else begin
                queue_item(make_req(nwrl_pkg::OP_CLEAR, $urandom, 16'($urandom),
                                    1'($urandom), 1'($urandom)));
                n_rules = ($urandom_range(0, 4) == 0)
                          ? $urandom_range(nwrl_pkg::TABLE_DEPTH - 2,
                                           nwrl_pkg::TABLE_DEPTH + 2)
                          : $urandom_range(0, 8);
                for (int i = 0; i < n_rules; i++) begin
                    queue_item(make_req(nwrl_pkg::OP_LOAD, pick_addr(), pick_port(),
                                        $urandom_range(0, 4) == 0,
                                        $urandom_range(0, 4) == 0));
                end
                n_lookups = $urandom_range(1, 8);
                for (int i = 0; i < n_lookups; i++) begin
                    queue_lookup();
                end
                n_random += 1 + n_rules + n_lookups;
            end
        end
        n_items = pending_req.size();

        // Synchronous reset, released at a falling edge by a nonblocking write so that the
        // driver, which runs at the same falling edge, still sees it asserted there.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_items || expected_rsp.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/nwrl_pkg.sv
rtl/core/nwrl_rule_mem.sv
rtl/core/nwrl_match_cmp.sv
rtl/core/nat_wildcard_rule_lookup_core.sv
tb/sv/testbench.sv
